// ===== rtl/core/ptd_pkg.sv =====
// shared types, codes and microcode table of the periodic task dispatcher
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

   // load arithmetic
   localparam logic [6:0] PERCENT   = 7'd100;
   localparam int         QUOT_BITS = 7;

   // request opcodes
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_SUSPEND   = 2'd1;
   localparam logic [1:0] OP_CONFIGURE = 2'd2;

   // response kinds
   localparam logic KIND_DISPATCH = 1'b0;
   localparam logic KIND_REPORT   = 1'b1;

   // program steps
   localparam logic [2:0] PC_IDLE   = 3'd0;
   localparam logic [2:0] PC_WALK   = 3'd1;
   localparam logic [2:0] PC_MUL    = 3'd2;
   localparam logic [2:0] PC_DIV    = 3'd3;
   localparam logic [2:0] PC_REPORT = 3'd4;

   // jump conditions: jump to target when true, else hold the step
   localparam logic [2:0] COND_NEVER     = 3'd0;
   localparam logic [2:0] COND_TICK      = 3'd1;
   localparam logic [2:0] COND_LAST_TASK = 3'd2;
   localparam logic [2:0] COND_DIV_DONE  = 3'd3;
   localparam logic [2:0] COND_ALWAYS    = 3'd4;

   typedef struct packed {
      logic       accept;
      logic       walk;
      logic       mul;
      logic       div;
      logic       report;
      logic [2:0] cond;
      logic [2:0] target;
   } ctl_type;

   typedef struct packed {
      logic mul;
      logic div;
   } ld_ctl_type;

   function automatic ctl_type ucode_rom(input logic [2:0] pc);
      ctl_type w;
      w = '{accept: 1'b1, walk: 1'b0, mul: 1'b0, div: 1'b0, report: 1'b0,
            cond: COND_TICK, target: PC_WALK};
      case (pc)
         PC_IDLE: begin
            w = '{accept: 1'b1, walk: 1'b0, mul: 1'b0, div: 1'b0, report: 1'b0,
                  cond: COND_TICK, target: PC_WALK};
         end
         PC_WALK: begin
            w = '{accept: 1'b0, walk: 1'b1, mul: 1'b0, div: 1'b0, report: 1'b0,
                  cond: COND_LAST_TASK, target: PC_MUL};
         end
         PC_MUL: begin
            w = '{accept: 1'b0, walk: 1'b0, mul: 1'b1, div: 1'b0, report: 1'b0,
                  cond: COND_ALWAYS, target: PC_DIV};
         end
         PC_DIV: begin
            w = '{accept: 1'b0, walk: 1'b0, mul: 1'b0, div: 1'b1, report: 1'b0,
                  cond: COND_DIV_DONE, target: PC_REPORT};
         end
         PC_REPORT: begin
            w = '{accept: 1'b0, walk: 1'b0, mul: 1'b0, div: 1'b0, report: 1'b1,
                  cond: COND_ALWAYS, target: PC_IDLE};
         end
         default: begin
            w = '{accept: 1'b0, walk: 1'b0, mul: 1'b0, div: 1'b0, report: 1'b0,
                  cond: COND_ALWAYS, target: PC_IDLE};
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/periodic_task_dispatcher.sv =====
// top level of the periodic task dispatcher: task table, microcoded walk, load report
// a tick runs through accept, a walk step per task, multiply, the bit-serial divide and
// report; suspend and configure finish in the accept step. A step that must emit stalls
// while the response side holds a pending transaction; the next request waits until
// the program is back idle
// reset: synchronous; clears marks, peak load, step counter, output valid; reload 16000
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatcher
   import ptd_pkg::*;
#(
   parameter int NUM_TASKS = 8
)(
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata, low bit up: task_index[3], period_ticks[16], first_delay[16],
   // busy_count[24], missed_ticks[8], zero fill[5]
   input  wire logic [71:0] req_tdata,
   // tuser: opcode[2]
   input  wire logic [1:0]  req_tuser,

   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata, low bit up: task_index_res[3], cpu_load[15], max_cpu_load[15],
   // zero fill[7]
   output logic [39:0]      rsp_tdata,
   // tuser: kind[1]
   output logic             rsp_tuser,
   output logic             rsp_tlast,

   // configuration: timer_reload
   input  wire logic        csr_we,
   input  wire logic [23:0] csr_wdata
);

   localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [TW-1:0] LAST_TASK = TW'(NUM_TASKS - 1);

   // request fields
   logic [1:0]  req_op;
   logic [2:0]  req_idx;
   logic [15:0] req_period;
   logic [15:0] req_delay;
   logic [23:0] req_busy;
   logic [7:0]  req_missed;
   logic        req_accept;

   assign req_op     = req_tuser;
   assign req_idx    = req_tdata[2:0];
   assign req_period = req_tdata[18:3];
   assign req_delay  = req_tdata[34:19];
   assign req_busy   = req_tdata[58:35];
   assign req_missed = req_tdata[66:59];

   // sequencer and datapath state
   logic [2:0]           pc_ff, pc_in;
   logic [TW-1:0]        task_ff, task_in;
   logic [23:0]          reload_ff, reload_in;
   logic [23:0]          busy_ff, busy_in;
   logic [7:0]           missed_ff, missed_in;
   logic [14:0]          peak_ff, peak_in;
   logic [NUM_TASKS-1:0] cfg_ff, cfg_in;
   logic [NUM_TASKS-1:0] susp_ff, susp_in;
   logic [15:0]          period_ff [NUM_TASKS];
   logic [15:0]          cd_ff [NUM_TASKS];

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [2:0]  rsp_idx_ff, rsp_idx_in;
   logic [14:0] rsp_load_ff, rsp_load_in;
   logic [14:0] rsp_max_ff, rsp_max_in;

   ctl_type              ctl;
   ld_ctl_type           ld_ctl;
   logic [QUOT_BITS-1:0] quot;
   logic                 div_last;

   logic          out_free;
   logic          stall;
   logic          take;
   logic          dispatch;
   logic [15:0]   cd_sel;
   logic [15:0]   cd_next;
   logic          idx_ok;
   logic [TW-1:0] widx;
   logic [14:0]   load;

   assign ctl = ucode_rom(pc_ff);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = ctl.accept;
   assign req_accept = req_tvalid && req_tready;

   // task under the walk: ready, configured and counted down to zero
   assign dispatch = cfg_ff[task_ff] && !susp_ff[task_ff] && (cd_ff[task_ff] == 16'd0);
   assign cd_sel   = dispatch ? period_ff[task_ff] : cd_ff[task_ff];
   assign cd_next  = (cd_sel != 16'd0) ? cd_sel - 16'd1 : 16'd0;

   // a step that must emit waits for the output register
   assign stall = ((ctl.walk && dispatch) || ctl.report) && !out_free;

   assign idx_ok = (32'(req_idx) < NUM_TASKS);
   assign widx   = TW'(req_idx);

   // busy percentage plus whole missed ticks
   assign load = 15'(missed_ff) * 15'(PERCENT) + 15'(quot);

   assign ld_ctl = '{mul: ctl.mul, div: ctl.div};

   ptd_load_unit u_load (
      .clock    (clock),
      .ctl      (ld_ctl),
      .busy     (busy_ff),
      .reload   (reload_ff),
      .quot     (quot),
      .div_last (div_last)
   );

   // jump condition
   always_comb begin
      case (ctl.cond)
         COND_NEVER:     take = 1'b0;
         COND_TICK:      take = req_accept && (req_op == OP_TICK);
         COND_LAST_TASK: take = (task_ff == LAST_TASK);
         COND_DIV_DONE:  take = div_last;
         COND_ALWAYS:    take = 1'b1;
         default:        take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in        = pc_ff;
      task_in      = task_ff;
      reload_in    = csr_we ? csr_wdata : reload_ff;
      busy_in      = busy_ff;
      missed_in    = missed_ff;
      peak_in      = peak_ff;
      cfg_in       = cfg_ff;
      susp_in      = susp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_load_in  = rsp_load_ff;
      rsp_max_in   = rsp_max_ff;

      if (!stall) begin
         if (take) begin
            pc_in = ctl.target;
         end

         // idle: decode the accepted request
         if (req_accept) begin
            case (req_op)
               OP_TICK: begin
                  busy_in   = req_busy;
                  missed_in = req_missed;
                  task_in   = '0;
               end
               OP_SUSPEND: begin
                  if (idx_ok) begin
                     susp_in[widx] = 1'b1;
                  end
               end
               OP_CONFIGURE: begin
                  if (idx_ok) begin
                     cfg_in[widx]  = 1'b1;
                     susp_in[widx] = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end

         // walk: one task a step, dispatch goes to the output register
         if (ctl.walk) begin
            task_in = task_ff + TW'(1);
            if (dispatch) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DISPATCH;
               rsp_last_in  = 1'b0;
               rsp_idx_in   = 3'(task_ff);
               rsp_load_in  = '0;
               rsp_max_in   = '0;
            end
         end

         // report closes the tick
         if (ctl.report) begin
            peak_in      = (load > peak_ff) ? load : peak_ff;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_REPORT;
            rsp_last_in  = 1'b1;
            rsp_idx_in   = '0;
            rsp_load_in  = load;
            rsp_max_in   = (load > peak_ff) ? load : peak_ff;
         end
      end
   end

   // task table entries, written by configure or by the walk
   always_ff @(posedge clock) begin
      if (req_accept && (req_op == OP_CONFIGURE) && idx_ok) begin
         period_ff[widx] <= req_period;
         cd_ff[widx]     <= req_delay;
      end else if (ctl.walk && !stall && cfg_ff[task_ff]) begin
         cd_ff[task_ff] <= cd_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         reload_ff    <= 24'd16000;
         peak_ff      <= '0;
         cfg_ff       <= '0;
         susp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         reload_ff    <= reload_in;
         peak_ff      <= peak_in;
         cfg_ff       <= cfg_in;
         susp_ff      <= susp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      busy_ff     <= busy_in;
      missed_ff   <= missed_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_load_ff <= rsp_load_in;
      rsp_max_ff  <= rsp_max_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_max_ff, rsp_load_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // an accepted tick always starts the walk
   a_tick_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_TICK)) |=> (pc_ff == PC_WALK))
      else $error("tick transaction did not start the task walk");

   // busy part of the load never exceeds one hundred percent
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_REPORT) |-> (quot <= PERCENT))
      else $error("busy percentage above one hundred");

   // a report ends the tick and carries a peak no lower than its load
   a_report_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_REPORT)) |->
         (rsp_last_ff && (rsp_max_ff >= rsp_load_ff)))
      else $error("load report without last or with peak below load");

endmodule

`default_nettype wire

// ===== rtl/core/ptd_load_unit.sv =====
// busy percentage unit: one multiply, then a restoring divide one bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module ptd_load_unit
   import ptd_pkg::*;
(
   input  wire logic                 clock,
   input  wire ld_ctl_type           ctl,
   input  wire logic [23:0]          busy,
   input  wire logic [23:0]          reload,
   output logic      [QUOT_BITS-1:0] quot,
   output logic                      div_last
);

   localparam int KW = $clog2(QUOT_BITS);

   logic [30:0]          rem_ff, rem_in;
   logic [QUOT_BITS-1:0] q_ff, q_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 zero_ff, zero_in;

   logic [23:0] busy_sat;
   logic [30:0] dsh;

   always_comb begin
      busy_sat = (busy > reload) ? reload : busy;
      dsh      = {7'd0, reload} << k_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      zero_in  = zero_ff;
      if (ctl.mul) begin
         rem_in  = 31'(busy_sat) * 31'(PERCENT);
         q_in    = '0;
         k_in    = KW'(QUOT_BITS - 1);
         zero_in = (reload == 24'd0);
      end else if (ctl.div) begin
         if (rem_ff >= dsh) begin
            rem_in = rem_ff - dsh;
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
         k_in = k_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      k_ff    <= k_in;
      zero_ff <= zero_in;
   end

   assign quot     = zero_ff ? '0 : q_ff;
   assign div_last = (k_ff == '0);

endmodule

`default_nettype wire
